// File: design/pwc_pkg.sv
// pwc_pkg: shared types, constants and helper functions for the payload
// whitening / CRC-32 block. No dependencies.
`timescale 1ns / 1ps
package pwc_pkg;

	localparam int NUM_LANES = 4;
	localparam int WORD_W    = 32;
	localparam int COUNT_W   = 3;

	localparam logic [WORD_W-1:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [WORD_W-1:0] GOLDEN    = 32'h9E3779B9;
	localparam logic [WORD_W-1:0] SEED_MIX  = 32'hD05FE123;
	localparam logic [WORD_W-1:0] SEED_ZERO = 32'hA5A5A5A5;
	localparam logic [WORD_W-1:0] ALL_ONES  = 32'hFFFFFFFF;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_SINGLE = 2'd1,
		MODE_PAIR   = 2'd2
	} whiten_mode_t;

	typedef logic [NUM_LANES-1:0][7:0] lane_bytes_t;

	// Seeds for both keystreams, raw and already stepped once.
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] a_step;
		logic [WORD_W-1:0] b_step;
	} seed_t;

	function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] c,
		input logic [7:0] b);
		logic [WORD_W-1:0] t;
		t = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			t = t[0] ? (CRC_POLY ^ (t >> 1)) : (t >> 1);
		end
		return t;
	endfunction

endpackage

// File: design/pwc_seed.sv
// pwc_seed: two-stage keystream seed generator (multiply, then mix/step).
// Depends on pwc_pkg.
`timescale 1ns / 1ps
module pwc_seed (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic [pwc_pkg::WORD_W-1:0]    frame_index,
	input  logic [pwc_pkg::WORD_W-1:0]    session_id,
	output pwc_pkg::seed_t                seeds
);
	import pwc_pkg::*;

	logic [WORD_W-1:0] prod_s1;
	logic [WORD_W-1:0] raw_a;
	logic [WORD_W-1:0] raw_b;
	logic [WORD_W-1:0] fix_a;
	logic [WORD_W-1:0] fix_b;
	seed_t             seeds_s2;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= frame_index * GOLDEN;
		end
	end

	// (idx+1)*G = idx*G + G
	assign raw_a = session_id ^ prod_s1 ^ SEED_MIX;
	assign raw_b = session_id ^ (prod_s1 + GOLDEN) ^ SEED_MIX;
	assign fix_a = (raw_a == '0) ? SEED_ZERO : raw_a;
	assign fix_b = (raw_b == '0) ? SEED_ZERO : raw_b;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			seeds_s2.a      <= fix_a;
			seeds_s2.b      <= fix_b;
			seeds_s2.a_step <= xs_step(fix_a);
			seeds_s2.b_step <= xs_step(fix_b);
		end
	end

	assign seeds = seeds_s2;

endmodule

// File: design/pwc_lane.sv
// pwc_lane: one byte lane; whitens a byte and blanks it past the byte count.
// Depends on pwc_pkg.
`timescale 1ns / 1ps
module pwc_lane #(
	parameter int LANE = 0
) (
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    key_byte,
	input  logic [pwc_pkg::COUNT_W-1:0]   byte_count,
	output logic [7:0]                    byte_out
);
	import pwc_pkg::*;

	logic lane_on;

	assign lane_on  = byte_count > COUNT_W'(LANE);
	assign byte_out = lane_on ? (data_byte ^ key_byte) : 8'd0;

endmodule

// File: design/pwc_crc_merge.sv
// pwc_crc_merge: folds the lane bytes of one beat into the running CRC-32.
// Depends on pwc_pkg.
`timescale 1ns / 1ps
module pwc_crc_merge (
	input  logic [pwc_pkg::WORD_W-1:0]    crc_in,
	input  pwc_pkg::lane_bytes_t          lane_bytes,
	input  logic [pwc_pkg::COUNT_W-1:0]   byte_count,
	output logic [pwc_pkg::WORD_W-1:0]    crc_out
);
	import pwc_pkg::*;

	logic [NUM_LANES:0][WORD_W-1:0] chain;

	always_comb begin
		chain[0] = crc_in;
		for (int i = 0; i < NUM_LANES; i++) begin
			chain[i+1] = (byte_count > COUNT_W'(i)) ?
				crc32_byte(chain[i], lane_bytes[i]) : chain[i];
		end
	end

	assign crc_out = chain[NUM_LANES];

endmodule

// File: design/payload_whitening_crc32.sv
// payload_whitening_crc32: top level; input pipeline, keystream/CRC state,
// byte lanes and output register. Depends on pwc_pkg, pwc_seed, pwc_lane, pwc_crc_merge.
`timescale 1ns / 1ps
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  input   | in_valid / in_ready    | frame_start whiten_mode frame_index data_in
//          |                        | byte_count last_word
//  output  | out_valid / out_ready  | data_out out_bytes out_last payload_crc
//  config  | cfg_wr_en              | cfg_wr_data (session_id)
//
// One beat per cycle sustained while out_ready is high; a beat passes stages 1, 2 and 3 in order.
// Stage 1 holds the seed multiply, stage 2 the seed mix and first xorshift step,
// stage 3 the keystream/CRC state update into the output register.
// Each stage takes a new beat when it is empty or its successor moves.
// Reset: keystreams 0xA5A5A5A5, CRC all ones, mode plain, session_id zero.
module payload_whitening_crc32 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pwc_pkg::WORD_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          frame_start,
	input  logic [1:0]                    whiten_mode,
	input  logic [pwc_pkg::WORD_W-1:0]    frame_index,
	input  logic [pwc_pkg::WORD_W-1:0]    data_in,
	input  logic [pwc_pkg::COUNT_W-1:0]   byte_count,
	input  logic                          last_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pwc_pkg::WORD_W-1:0]    data_out,
	output logic [pwc_pkg::COUNT_W-1:0]   out_bytes,
	output logic                          out_last,
	output logic [pwc_pkg::WORD_W-1:0]    payload_crc
);
	import pwc_pkg::*;

	logic [WORD_W-1:0]  session_q;
	logic [WORD_W-1:0]  ks_a_q;
	logic [WORD_W-1:0]  ks_b_q;
	logic [WORD_W-1:0]  crc_q;
	whiten_mode_t       frame_mode_q;

	logic               v_s1, v_s2, out_valid_q;
	logic               start_s1, start_s2;
	whiten_mode_t       mode_s1, mode_s2;
	logic [WORD_W-1:0]  data_s1, data_s2;
	logic [COUNT_W-1:0] n_s1, n_s2;
	logic               last_s1, last_s2;

	logic [WORD_W-1:0]  data_out_q;
	logic [COUNT_W-1:0] out_bytes_q;
	logic               out_last_q;
	logic [WORD_W-1:0]  crc_out_q;

	logic               rdy1, rdy2, rdy3;
	logic               en1, en2, en3;
	whiten_mode_t       mode_in;
	logic [COUNT_W-1:0] n_in;
	seed_t              seeds;

	whiten_mode_t       eff_mode;
	logic [WORD_W-1:0]  cur_a, cur_b, stp_a, stp_b;
	logic [WORD_W-1:0]  nxt_a, nxt_b, key;
	logic [WORD_W-1:0]  crc_base, crc_new;
	lane_bytes_t        lane_bytes;

	assign rdy3     = !out_valid_q || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign en1      = in_valid && rdy1;
	assign en2      = v_s1 && rdy2;
	assign en3      = v_s2 && rdy3;

	always_comb begin
		unique case (whiten_mode)
			MODE_SINGLE: mode_in = MODE_SINGLE;
			MODE_PAIR:   mode_in = MODE_PAIR;
			default:     mode_in = MODE_PLAIN;
		endcase
	end

	assign n_in = (byte_count > COUNT_W'(NUM_LANES)) ? COUNT_W'(NUM_LANES) : byte_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= '0;
		end else if (cfg_wr_en) begin
			session_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			start_s1 <= frame_start;
			mode_s1  <= mode_in;
			data_s1  <= data_in;
			n_s1     <= n_in;
			last_s1  <= last_word;
		end
		if (en2) begin
			start_s2 <= start_s1;
			mode_s2  <= mode_s1;
			data_s2  <= data_s1;
			n_s2     <= n_s1;
			last_s2  <= last_s1;
		end
	end

	pwc_seed u_seed (
		.clk         (clk),
		.en_s1       (en1),
		.en_s2       (en2),
		.frame_index (frame_index),
		.session_id  (session_q),
		.seeds       (seeds)
	);

	assign eff_mode = start_s2 ? mode_s2 : frame_mode_q;
	assign cur_a    = start_s2 ? seeds.a : ks_a_q;
	assign cur_b    = start_s2 ? seeds.b : ks_b_q;
	assign stp_a    = start_s2 ? seeds.a_step : xs_step(ks_a_q);
	assign stp_b    = start_s2 ? seeds.b_step : xs_step(ks_b_q);

	always_comb begin
		nxt_a = cur_a;
		nxt_b = cur_b;
		key   = '0;
		if (n_s2 != '0) begin
			case (eff_mode)
				MODE_SINGLE: begin
					nxt_a = stp_a;
					key   = stp_a;
				end
				MODE_PAIR: begin
					nxt_a = stp_a;
					nxt_b = stp_b;
					key   = stp_a ^ stp_b;
				end
				default: begin
					key = '0;
				end
			endcase
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		pwc_lane #(
			.LANE (g)
		) u_lane (
			.data_byte  (data_s2[8*g +: 8]),
			.key_byte   (key[8*g +: 8]),
			.byte_count (n_s2),
			.byte_out   (lane_bytes[g])
		);
	end

	assign crc_base = start_s2 ? ALL_ONES : crc_q;

	pwc_crc_merge u_crc (
		.crc_in     (crc_base),
		.lane_bytes (lane_bytes),
		.byte_count (n_s2),
		.crc_out    (crc_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_a_q       <= SEED_ZERO;
			ks_b_q       <= SEED_ZERO;
			crc_q        <= ALL_ONES;
			frame_mode_q <= MODE_PLAIN;
		end else if (en3) begin
			ks_a_q       <= nxt_a;
			ks_b_q       <= nxt_b;
			crc_q        <= last_s2 ? ALL_ONES : crc_new;
			frame_mode_q <= eff_mode;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			data_out_q  <= lane_bytes;
			out_bytes_q <= n_s2;
			out_last_q  <= last_s2;
			crc_out_q   <= last_s2 ? (crc_new ^ ALL_ONES) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_out    = data_out_q;
	assign out_bytes   = out_bytes_q;
	assign out_last    = out_last_q;
	assign payload_crc = crc_out_q;

endmodule

// File: tb/tb_payload_whitening_crc32.sv
// tb_payload_whitening_crc32: self-checking bench for the payload whitening / CRC-32 block.
// Holds a scoreboard class that predicts every output beat and random handshake drivers.
// Depends on pwc_pkg and payload_whitening_crc32.
`timescale 1ns / 1ps
module tb_payload_whitening_crc32;
	import pwc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'b11;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int HOLD_OFF_CYCLES = 80;

	typedef struct packed {
		logic               start;
		logic [1:0]         mode;
		logic [WORD_W-1:0]  idx;
		logic [WORD_W-1:0]  data;
		logic [COUNT_W-1:0] cnt;
		logic               last;
	} word_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0]  data;
		logic [COUNT_W-1:0] bytes;
		logic               last;
		logic [WORD_W-1:0]  crc;
	} result_beat_t;

	class whiten_scoreboard;
		logic [WORD_W-1:0] session;
		logic [WORD_W-1:0] ks_a;
		logic [WORD_W-1:0] ks_b;
		logic [WORD_W-1:0] crc_acc;
		whiten_mode_t      mode_q;
		result_beat_t      expected_q[$];
		int                errors;

		function new();
			session = '0;
			ks_a = SEED_ZERO;
			ks_b = SEED_ZERO;
			crc_acc = ALL_ONES;
			mode_q = MODE_PLAIN;
			errors = 0;
		endfunction

		function logic [WORD_W-1:0] seed_of(logic [WORD_W-1:0] i);
			logic [WORD_W-1:0] prod;
			logic [WORD_W-1:0] s;
			prod = i * GOLDEN;
			s = session ^ prod ^ SEED_MIX;
			return (s == '0) ? SEED_ZERO : s;
		endfunction

		function logic [WORD_W-1:0] xorshift(logic [WORD_W-1:0] s);
			logic [WORD_W-1:0] t;
			t = s ^ (s << 13);
			t = t ^ (t >> 17);
			return t ^ (t << 5);
		endfunction

		function logic [WORD_W-1:0] crc_update(logic [WORD_W-1:0] c, logic [7:0] b);
			logic [WORD_W-1:0] t;
			t = c ^ {24'd0, b};
			for (int k = 0; k < 8; k++)
				t = (t >> 1) ^ (t[0] ? CRC_POLY : '0);
			return t;
		endfunction

		function void note_input(word_beat_t w);
			result_beat_t      r;
			logic [WORD_W-1:0] key;
			logic [WORD_W-1:0] mixed;
			int                n;
			n = (w.cnt > NUM_LANES) ? NUM_LANES : int'(w.cnt);
			if (w.start) begin
				case (w.mode)
					MODE_SINGLE: mode_q = MODE_SINGLE;
					MODE_PAIR:   mode_q = MODE_PAIR;
					default:     mode_q = MODE_PLAIN;
				endcase
				ks_a = seed_of(w.idx);
				ks_b = seed_of(w.idx + 32'd1);
				crc_acc = ALL_ONES;
			end
			key = '0;
			r = '0;
			if (n > 0) begin
				if (mode_q != MODE_PLAIN) begin
					ks_a = xorshift(ks_a);
					key = ks_a;
				end
				if (mode_q == MODE_PAIR) begin
					ks_b = xorshift(ks_b);
					key = key ^ ks_b;
				end
				mixed = w.data ^ key;
				for (int i = 0; i < n; i++) begin
					r.data[8*i +: 8] = mixed[8*i +: 8];
					crc_acc = crc_update(crc_acc, mixed[8*i +: 8]);
				end
			end
			r.bytes = n[COUNT_W-1:0];
			r.last = w.last;
			if (w.last) begin
				r.crc = ~crc_acc;
				crc_acc = ALL_ONES;
			end
			expected_q.push_back(r);
		endfunction

		task report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			$display("ERROR at %0t ns: %s expected %h got %h", $time, field, want, got);
			errors++;
		endtask

		task check_result(result_beat_t got);
			result_beat_t want;
			if (expected_q.size() == 0) begin
				report("unexpected beat, data_out", '0, got.data);
				return;
			end
			want = expected_q.pop_front();
			if (got.data !== want.data)
				report("data_out", want.data, got.data);
			if (got.bytes !== want.bytes)
				report("out_bytes", WORD_W'(want.bytes), WORD_W'(got.bytes));
			if (got.last !== want.last)
				report("out_last", WORD_W'(want.last), WORD_W'(got.last));
			if (got.crc !== want.crc)
				report("payload_crc", want.crc, got.crc);
		endtask

		function bit idle();
			return expected_q.size() == 0;
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [WORD_W-1:0]   cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic                frame_start;
	logic [1:0]          whiten_mode;
	logic [WORD_W-1:0]   frame_index;
	logic [WORD_W-1:0]   data_in;
	logic [COUNT_W-1:0]  byte_count;
	logic                last_word;
	logic                out_valid;
	logic                out_ready;
	logic [WORD_W-1:0]   data_out;
	logic [COUNT_W-1:0]  out_bytes;
	logic                out_last;
	logic [WORD_W-1:0]   payload_crc;

	whiten_scoreboard sb;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int words_sent = 0;

	payload_whitening_crc32 u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_start (frame_start),
		.whiten_mode (whiten_mode),
		.frame_index (frame_index),
		.data_in     (data_in),
		.byte_count  (byte_count),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_out    (data_out),
		.out_bytes   (out_bytes),
		.out_last    (out_last),
		.payload_crc (payload_crc)
	);

	always #10 clk = ~clk;

	// receiver: random stalls, plus a counted hold-off when requested
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{data: data_out, bytes: out_bytes, last: out_last,
				crc: payload_crc});
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic word_beat_t beat(logic st, logic [1:0] md, logic [WORD_W-1:0] ix,
		logic [WORD_W-1:0] dt, logic [COUNT_W-1:0] bc, logic lst);
		word_beat_t w;
		w.start = st;
		w.mode = md;
		w.idx = ix;
		w.data = dt;
		w.cnt = bc;
		w.last = lst;
		return w;
	endfunction

	// entered and left at a rising edge; valid stays up after the beat is taken
	task automatic send_word(word_beat_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_start <= w.start;
		whiten_mode <= w.mode;
		frame_index <= w.idx;
		data_in <= w.data;
		byte_count <= w.cnt;
		last_word <= w.last;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (!sb.idle())
			@(posedge clk);
	endtask

	task automatic write_session(logic [WORD_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.session = value;
	endtask

	task automatic send_frame();
		logic [1:0]         md;
		logic [WORD_W-1:0]  ix;
		logic [COUNT_W-1:0] bc;
		int                 len;
		int                 sel;
		if ($urandom_range(9) == 0) begin
			// stray words outside any frame
			len = $urandom_range(1, 3);
			for (int k = 0; k < len; k++)
				send_word(beat(1'b0, 2'($urandom_range(3)), $urandom, $urandom,
					3'($urandom_range(7)), 1'($urandom_range(1))));
			return;
		end
		md = ($urandom_range(11) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
		sel = $urandom_range(15);
		ix = (sel == 0) ? '0 : (sel == 1) ? ALL_ONES : $urandom;
		len = ($urandom_range(7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
		for (int k = 0; k < len; k++) begin
			sel = $urandom_range(11);
			if (k == len - 1)
				bc = (sel < 2) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
			else
				bc = (sel == 0) ? 3'($urandom_range(3)) :
					(sel == 1) ? 3'($urandom_range(5, 7)) : 3'd4;
			send_word(beat(k == 0, (k == 0) ? md : 2'($urandom_range(3)),
				(k == 0) ? ix : $urandom, $urandom, bc, k == len - 1));
		end
	endtask

	task automatic run_phase(logic [WORD_W-1:0] session, int idle, int stall, int hold);
		int target;
		drain();
		write_session(session);
		idle_pct = idle;
		stall_pct = stall;
		if (hold > 0)
			hold_cycles = hold;
		target = words_sent + ITEMS_PER_PHASE;
		while (words_sent < target)
			send_frame();
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		frame_start <= 1'b0;
		whiten_mode <= MODE_PLAIN;
		frame_index <= '0;
		data_in <= '0;
		byte_count <= '0;
		last_word <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, words before any frame, then an empty frame and words after it
		send_word(beat(1'b0, MODE_PAIR, 32'd7, 32'h12345678, 3'd4, 1'b0));
		send_word(beat(1'b0, MODE_SINGLE, 32'd9, 32'hCAFEF00D, 3'd2, 1'b1));
		send_word(beat(1'b1, MODE_PAIR, 32'd5, 32'h0BADBEEF, 3'd0, 1'b1));
		send_word(beat(1'b0, MODE_PLAIN, 32'd0, 32'h89ABCDEF, 3'd4, 1'b0));
		send_word(beat(1'b0, MODE_PLAIN, 32'd0, 32'h00000000, 3'd4, 1'b1));
		// single mode, oversize count, short word mid-frame
		send_word(beat(1'b1, MODE_SINGLE, 32'd0, 32'h00000000, 3'd4, 1'b0));
		send_word(beat(1'b0, MODE_PLAIN, ALL_ONES, 32'hFFFFFFFF, 3'd7, 1'b0));
		send_word(beat(1'b0, MODE_PAIR, 32'd0, 32'hA5A5A5A5, 3'd3, 1'b0));
		send_word(beat(1'b0, MODE_UNUSED, 32'd0, 32'h00000000, 3'd4, 1'b1));
		// pair mode with index wrap, empty word mid-frame
		send_word(beat(1'b1, MODE_PAIR, ALL_ONES, 32'hFFFFFFFF, 3'd4, 1'b0));
		send_word(beat(1'b0, MODE_PAIR, ALL_ONES, 32'h5A5A5A5A, 3'd0, 1'b0));
		send_word(beat(1'b0, MODE_PAIR, ALL_ONES, 32'h00000000, 3'd1, 1'b1));
		// unused mode acts as plain
		send_word(beat(1'b1, MODE_UNUSED, 32'd123, 32'hDEADBEEF, 3'd5, 1'b0));
		send_word(beat(1'b0, MODE_PAIR, 32'd0, 32'h01020304, 3'd6, 1'b1));
		send_word(beat(1'b1, MODE_PLAIN, 32'h80000000, 32'hFFFFFFFF, 3'd4, 1'b1));

		// session chosen so that seeds come out zero
		drain();
		write_session(SEED_MIX);
		send_word(beat(1'b1, MODE_PAIR, 32'd0, 32'h11111111, 3'd4, 1'b0));
		send_word(beat(1'b0, MODE_PAIR, 32'd0, 32'h22222222, 3'd4, 1'b1));
		send_word(beat(1'b1, MODE_SINGLE, 32'd0, 32'h33333333, 3'd4, 1'b1));
		send_word(beat(1'b1, MODE_PAIR, ALL_ONES, 32'h44444444, 3'd4, 1'b0));
		send_word(beat(1'b0, MODE_PAIR, 32'd0, 32'h55555555, 3'd3, 1'b1));

		run_phase(ALL_ONES, 0, 0, 0);
		run_phase($urandom, 87, 0, 0);
		run_phase('0, 0, 87, 0);
		run_phase($urandom, 24, 24, 0);
		run_phase($urandom, 0, 30, HOLD_OFF_CYCLES);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.idle())
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
